>>> sv/ccf_pkg.sv
package ccf_pkg;

  typedef enum logic [2:0] {
    KIND_TICK     = 3'd0,
    KIND_DRIVE    = 3'd1,
    KIND_ENABLE   = 3'd2,
    KIND_DISABLE  = 3'd3,
    KIND_CLEAR    = 3'd4,
    KIND_FEEDBACK = 3'd5
  } ccf_kind_e;

  typedef enum logic [1:0] {
    REG_LINEAR_LIMIT = 2'd0,
    REG_SPIN_LIMIT   = 2'd1,
    REG_SETTLE_TICKS = 2'd2
  } ccf_reg_e;

  localparam logic [1:0]  MODE_ACKERMANN = 2'd0;
  localparam logic [1:0]  MODE_SPIN      = 2'd2;
  localparam logic [2:0]  MODE_UNKNOWN   = 3'd7;

  localparam logic [10:0] ID_MOTION    = 11'h111;
  localparam logic [10:0] ID_MODE      = 11'h141;
  localparam logic [10:0] ID_CONTROL   = 11'h421;
  localparam logic [10:0] ID_CLEAR     = 11'h441;
  localparam logic [28:0] ID_FB_SYSTEM = 29'h211;

  localparam logic [3:0]  LEN_SHORT = 4'd1;
  localparam logic [3:0]  LEN_FULL  = 4'd8;

  localparam logic [14:0] LINEAR_LIMIT_RST = 15'd1500;
  localparam logic [14:0] SPIN_LIMIT_RST   = 15'd3259;
  localparam logic [15:0] SETTLE_TICKS_RST = 16'd25;

  typedef struct packed {
    logic [2:0]         kind;
    logic [1:0]         drive_mode;
    logic signed [15:0] linear_speed;
    logic signed [15:0] angular_rate;
    logic [28:0]        rx_id;
    logic [3:0]         rx_len;
    logic [63:0]        rx_data;
  } ccf_in_t;

  typedef struct packed {
    logic        frame_valid;
    logic [10:0] frame_id;
    logic [3:0]  frame_len;
    logic [63:0] frame_data;
    logic        last;
    logic [15:0] voltage_decivolts;
    logic        estop_active;
    logic        link_seen;
  } ccf_out_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] value;
  } ccf_cfg_t;

  // push requests from the core into the result queue
  typedef struct packed {
    logic first;
    logic second;
  } ccf_push_t;

endpackage

>>> sv/ccf_stream_if.sv
interface ccf_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/ccf_core.sv
module ccf_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  ccf_stream_if.sink       in_i,
  ccf_stream_if.sink       cfg_i,
  input  logic             room_i,
  output ccf_pkg::ccf_push_t push_o,
  output ccf_pkg::ccf_out_t  res0_o,
  output ccf_pkg::ccf_out_t  res1_o
);
  import ccf_pkg::*;

  logic        in_vld_q;
  ccf_in_t     in_q;
  logic        go;

  logic [14:0] linear_limit_q, spin_limit_q;
  logic [15:0] settle_ticks_q;

  logic        enabled_q, enabled_d;
  logic [1:0]  wanted_q, wanted_d;
  logic [2:0]  active_q, active_d;
  logic signed [15:0] held_lin_q, held_lin_d, held_ang_q, held_ang_d;
  logic [15:0] settle_q, settle_d, settle_eff;
  logic [15:0] volt_q, volt_d;
  logic        estop_q, estop_d, link_q, link_d;

  logic        mode_chg;
  logic signed [15:0] tick_lin, tick_ang;
  logic [63:0] motion_data;
  ccf_out_t    none_res, mode_res, motion_res, ctrl_res;

  function automatic logic signed [15:0] clamp_lim(logic signed [15:0] v, logic [14:0] lim);
    logic signed [16:0] l;
    logic signed [16:0] w;
    logic signed [15:0] r;
    l = $signed({2'b00, lim});
    w = {v[15], v};
    if (w < -l) r = 16'(-l);
    else if (w > l) r = 16'(l);
    else r = v;
    return r;
  endfunction

  assign go = in_vld_q & room_i;
  assign in_i.ready = ~in_vld_q | go;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_q <= in_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      linear_limit_q <= LINEAR_LIMIT_RST;
      spin_limit_q   <= SPIN_LIMIT_RST;
      settle_ticks_q <= SETTLE_TICKS_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        REG_LINEAR_LIMIT: linear_limit_q <= cfg_i.data.value[14:0];
        REG_SPIN_LIMIT:   spin_limit_q   <= cfg_i.data.value[14:0];
        REG_SETTLE_TICKS: settle_ticks_q <= cfg_i.data.value;
        default: ;
      endcase
    end
  end

  // a tick on a mode change reloads the settle count before it is used
  assign mode_chg   = enabled_q && ({1'b0, wanted_q} != active_q);
  assign settle_eff = mode_chg ? settle_ticks_q : settle_q;
  assign tick_lin   = (settle_eff != 16'd0) ? 16'sd0 : clamp_lim(held_lin_q, linear_limit_q);
  assign tick_ang   = (settle_eff != 16'd0) ? 16'sd0 : clamp_lim(held_ang_q, spin_limit_q);
  assign motion_data = {tick_lin, tick_ang, 32'd0};

  always_comb begin
    enabled_d  = enabled_q;
    wanted_d   = wanted_q;
    active_d   = active_q;
    held_lin_d = held_lin_q;
    held_ang_d = held_ang_q;
    settle_d   = settle_q;
    volt_d     = volt_q;
    estop_d    = estop_q;
    link_d     = link_q;
    case (in_q.kind)
      KIND_TICK: begin
        if (enabled_q) begin
          active_d = {1'b0, wanted_q};
          settle_d = (settle_eff != 16'd0) ? settle_eff - 16'd1 : settle_eff;
        end
      end
      KIND_DRIVE: begin
        wanted_d = in_q.drive_mode;
        if (in_q.drive_mode == MODE_SPIN) begin
          held_ang_d = clamp_lim(in_q.angular_rate, spin_limit_q);
          held_lin_d = 16'sd0;
        end else begin
          held_lin_d = clamp_lim(in_q.linear_speed, linear_limit_q);
          held_ang_d = 16'sd0;
        end
      end
      KIND_ENABLE: begin
        enabled_d  = 1'b1;
        held_lin_d = 16'sd0;
        held_ang_d = 16'sd0;
        active_d   = MODE_UNKNOWN;
        wanted_d   = MODE_ACKERMANN;
      end
      KIND_DISABLE: begin
        enabled_d  = 1'b0;
        held_lin_d = 16'sd0;
        held_ang_d = 16'sd0;
      end
      KIND_FEEDBACK: begin
        link_d = 1'b1;
        if (in_q.rx_id == ID_FB_SYSTEM && in_q.rx_len >= LEN_FULL) begin
          volt_d  = in_q.rx_data[47:32];
          estop_d = in_q.rx_data[7];
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    none_res = '0;
    none_res.last              = 1'b1;
    none_res.voltage_decivolts = volt_d;
    none_res.estop_active      = estop_d;
    none_res.link_seen         = link_d;

    mode_res             = none_res;
    mode_res.frame_valid = 1'b1;
    mode_res.frame_id    = ID_MODE;
    mode_res.frame_len   = LEN_SHORT;
    mode_res.frame_data  = {6'd0, wanted_q, 56'd0};
    mode_res.last        = 1'b0;

    motion_res             = none_res;
    motion_res.frame_valid = 1'b1;
    motion_res.frame_id    = ID_MOTION;
    motion_res.frame_len   = LEN_FULL;
    motion_res.frame_data  = motion_data;

    ctrl_res             = none_res;
    ctrl_res.frame_valid = 1'b1;
    ctrl_res.frame_len   = LEN_SHORT;

    res0_o = none_res;
    res1_o = motion_res;
    push_o.first  = go;
    push_o.second = 1'b0;
    case (in_q.kind)
      KIND_TICK: begin
        if (enabled_q) begin
          res0_o = mode_chg ? mode_res : motion_res;
          push_o.second = go & mode_chg;
        end
      end
      KIND_ENABLE: begin
        res0_o = ctrl_res;
        res0_o.frame_id   = ID_CONTROL;
        res0_o.frame_data = {8'd1, 56'd0};
      end
      KIND_DISABLE: begin
        res0_o = ctrl_res;
        res0_o.frame_id = ID_CONTROL;
      end
      KIND_CLEAR: begin
        res0_o = ctrl_res;
        res0_o.frame_id = ID_CLEAR;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q  <= 1'b0;
      wanted_q   <= MODE_ACKERMANN;
      active_q   <= {1'b0, MODE_ACKERMANN};
      held_lin_q <= 16'sd0;
      held_ang_q <= 16'sd0;
      settle_q   <= 16'd0;
      volt_q     <= 16'd0;
      estop_q    <= 1'b0;
      link_q     <= 1'b0;
    end else if (go) begin
      enabled_q  <= enabled_d;
      wanted_q   <= wanted_d;
      active_q   <= active_d;
      held_lin_q <= held_lin_d;
      held_ang_q <= held_ang_d;
      settle_q   <= settle_d;
      volt_q     <= volt_d;
      estop_q    <= estop_d;
      link_q     <= link_d;
    end
  end

endmodule

>>> sv/ccf_out_fifo.sv
module ccf_out_fifo #(
  parameter int DEPTH = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ccf_pkg::ccf_push_t push_i,
  input  ccf_pkg::ccf_out_t  res0_i,
  input  ccf_pkg::ccf_out_t  res1_i,
  output logic               room_o,
  ccf_stream_if.source       out_o
);
  import ccf_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(DEPTH - 2);

  ccf_out_t          mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q, wr_next, wr_after;
  logic [CNT_W-1:0]  count_q;
  logic              pop;

  function automatic logic [PTR_W-1:0] bump(logic [PTR_W-1:0] p);
    return (p == LAST_PTR) ? '0 : p + PTR_W'(1);
  endfunction

  assign wr_next  = bump(wr_q);
  assign wr_after = bump(wr_next);
  assign room_o    = count_q <= ROOM_MAX;
  assign out_o.valid = count_q != '0;
  assign out_o.data  = mem_q[rd_q];
  assign pop = out_o.valid & out_o.ready;

  always_ff @(posedge clk_i) begin
    if (push_i.first) begin
      mem_q[wr_q] <= res0_i;
    end
    if (push_i.second) begin
      mem_q[wr_next] <= res1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i.second) begin
        wr_q <= wr_after;
      end else if (push_i.first) begin
        wr_q <= wr_next;
      end
      if (pop) begin
        rd_q <= bump(rd_q);
      end
      count_q <= count_q + CNT_W'(push_i.first) + CNT_W'(push_i.second) - CNT_W'(pop);
    end
  end

endmodule

>>> sv/chassis_can_command_framer.sv
// Channel  Role    Payload     Transfer when
// in_i     sink    ccf_in_t    in_i.valid & in_i.ready
// cfg_i    sink    ccf_cfg_t   cfg_i.valid & cfg_i.ready (ready held high)
// out_o    source  ccf_out_t   out_o.valid & out_o.ready
//
// One event per cycle while the queue has room: an event waits in the input
// register, then its results are written into the result queue in the same
// edge it retires. A tick that changes mode makes two results, so the output
// side sets the sustained rate at one result per cycle. Input stalls while
// the queue has fewer than two free slots. Reset is asynchronous, clears the
// control registers and loads the register defaults; no clearing pass follows.
module chassis_can_command_framer #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  ccf_stream_if.sink   in_i,
  ccf_stream_if.sink   cfg_i,
  ccf_stream_if.source out_o
);
  import ccf_pkg::*;

  ccf_push_t push;
  ccf_out_t  res0, res1;
  logic      room;

  ccf_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg_i),
    .room_i (room),
    .push_o (push),
    .res0_o (res0),
    .res1_o (res1)
  );

  ccf_out_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .res0_i (res0),
    .res1_i (res1),
    .room_o (room),
    .out_o  (out_o)
  );

endmodule

>>> dv/tb_chassis_can_command_framer.sv
`timescale 1ns / 100ps

module tb_chassis_can_command_framer;
  import ccf_pkg::*;

  localparam logic [2:0] KIND_SPARE_LO = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;
  localparam logic [1:0] MODE_TILT     = 2'd1;
  localparam logic [1:0] MODE_PARK     = 2'd3;
  localparam logic [1:0] REG_UNUSED    = 2'd3;
  localparam int QUIET_LIMIT = 5000;
  localparam int LONG_HOLD   = 300;
  localparam int PHASE_ITEMS = 150;
  localparam int NUM_PHASES  = 7;

  logic clk;
  logic rst_n;

  ccf_stream_if #(.payload_t(ccf_in_t))  ev_if ();
  ccf_stream_if #(.payload_t(ccf_cfg_t)) cfg_if ();
  ccf_stream_if #(.payload_t(ccf_out_t)) frm_if ();

  chassis_can_command_framer dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (ev_if),
    .cfg_i  (cfg_if),
    .out_o  (frm_if)
  );

  // framer state as the testbench tracks it
  logic [14:0]        lin_lim;
  logic [14:0]        spin_lim;
  logic [15:0]        settle_cfg;
  logic               en_q;
  logic [1:0]         goal_mode;
  logic [2:0]         act_mode;
  logic signed [15:0] hold_lin;
  logic signed [15:0] hold_ang;
  logic [15:0]        settle_cnt;
  logic [15:0]        batt_v;
  logic               estop_q;
  logic               link_q;

  ccf_in_t  pend_events[$];
  ccf_out_t expected_frames[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mism_cnt       = 0;
  int hold_token     = 0;
  int hold_seen      = 0;
  int hold_left      = 0;
  int quiet_cycles   = 0;
  logic [1:0] rand_mode = MODE_ACKERMANN;

  function automatic logic signed [15:0] clamp_speed(logic signed [15:0] v, logic [14:0] lim);
    int l;
    int x;
    l = int'(lim);
    x = int'(v);
    if (x < -l) return 16'(-l);
    if (x > l) return 16'(l);
    return v;
  endfunction

  function automatic void push_frame(logic vld, logic [10:0] id, logic [3:0] len,
                                     logic [63:0] data, logic lst);
    ccf_out_t f;
    f.frame_valid       = vld;
    f.frame_id          = id;
    f.frame_len         = len;
    f.frame_data        = data;
    f.last              = lst;
    f.voltage_decivolts = batt_v;
    f.estop_active      = estop_q;
    f.link_seen         = link_q;
    expected_frames.push_back(f);
  endfunction

  function automatic void apply_register(ccf_cfg_t c);
    case (c.index)
      REG_LINEAR_LIMIT: lin_lim = c.value[14:0];
      REG_SPIN_LIMIT:   spin_lim = c.value[14:0];
      REG_SETTLE_TICKS: settle_cfg = c.value;
      default: ;
    endcase
  endfunction

  // work out the frames one accepted event produces and update the state
  function automatic void frame_event(ccf_in_t ev);
    logic signed [15:0] l;
    logic signed [15:0] a;
    logic sent;
    sent = 1'b0;
    case (ev.kind)
      KIND_TICK: begin
        if (en_q) begin
          if ({1'b0, goal_mode} != act_mode) begin
            act_mode   = {1'b0, goal_mode};
            settle_cnt = settle_cfg;
            push_frame(1'b1, ID_MODE, LEN_SHORT, {6'b0, goal_mode, 56'b0}, 1'b0);
          end
          l = clamp_speed(hold_lin, lin_lim);
          a = clamp_speed(hold_ang, spin_lim);
          if (settle_cnt != 16'd0) begin
            settle_cnt = settle_cnt - 16'd1;
            l = '0;
            a = '0;
          end
          push_frame(1'b1, ID_MOTION, LEN_FULL, {l, a, 32'b0}, 1'b1);
          sent = 1'b1;
        end
      end
      KIND_DRIVE: begin
        goal_mode = ev.drive_mode;
        if (ev.drive_mode == MODE_SPIN) begin
          hold_ang = clamp_speed(ev.angular_rate, spin_lim);
          hold_lin = '0;
        end else begin
          hold_lin = clamp_speed(ev.linear_speed, lin_lim);
          hold_ang = '0;
        end
      end
      KIND_ENABLE: begin
        en_q      = 1'b1;
        hold_lin  = '0;
        hold_ang  = '0;
        act_mode  = MODE_UNKNOWN;
        goal_mode = MODE_ACKERMANN;
        push_frame(1'b1, ID_CONTROL, LEN_SHORT, {8'd1, 56'b0}, 1'b1);
        sent = 1'b1;
      end
      KIND_DISABLE: begin
        hold_lin = '0;
        hold_ang = '0;
        en_q     = 1'b0;
        push_frame(1'b1, ID_CONTROL, LEN_SHORT, 64'b0, 1'b1);
        sent = 1'b1;
      end
      KIND_CLEAR: begin
        push_frame(1'b1, ID_CLEAR, LEN_SHORT, 64'b0, 1'b1);
        sent = 1'b1;
      end
      KIND_FEEDBACK: begin
        link_q = 1'b1;
        // length above eight still counts as a full frame
        if (ev.rx_id == ID_FB_SYSTEM && ev.rx_len >= LEN_FULL) begin
          batt_v  = ev.rx_data[47:32];
          estop_q = ev.rx_data[7];
        end
      end
      default: ;
    endcase
    if (!sent) push_frame(1'b0, '0, '0, '0, 1'b1);
  endfunction

  function automatic ccf_in_t mk_event(logic [2:0] kind, logic [1:0] mode,
                                       logic signed [15:0] lin, logic signed [15:0] ang,
                                       logic [28:0] id, logic [3:0] len, logic [63:0] data);
    ccf_in_t ev;
    ev.kind         = kind;
    ev.drive_mode   = mode;
    ev.linear_speed = lin;
    ev.angular_rate = ang;
    ev.rx_id        = id;
    ev.rx_len       = len;
    ev.rx_data      = data;
    return ev;
  endfunction

  // mostly ticks and drives with sticky modes, so settling and motion both show up
  function automatic ccf_in_t rand_event();
    ccf_in_t ev;
    int pick;
    ev.kind         = KIND_TICK;
    ev.drive_mode   = 2'($urandom);
    ev.linear_speed = 16'($urandom);
    ev.angular_rate = 16'($urandom);
    ev.rx_id        = 29'($urandom);
    ev.rx_len       = 4'($urandom);
    ev.rx_data      = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 40) begin
      ev.kind = KIND_TICK;
    end else if (pick < 62) begin
      ev.kind = KIND_DRIVE;
      if ($urandom_range(9) < 3) rand_mode = 2'($urandom);
      ev.drive_mode = rand_mode;
      if ($urandom_range(1) == 0) begin
        ev.linear_speed = 16'(int'($urandom_range(4000)) - 2000);
        ev.angular_rate = 16'(int'($urandom_range(4000)) - 2000);
      end
    end else if (pick < 66) begin
      ev.kind = KIND_ENABLE;
    end else if (pick < 69) begin
      ev.kind = KIND_DISABLE;
    end else if (pick < 72) begin
      ev.kind = KIND_CLEAR;
    end else if (pick < 94) begin
      ev.kind = KIND_FEEDBACK;
      if ($urandom_range(9) < 6) ev.rx_id = ID_FB_SYSTEM;
      if ($urandom_range(9) < 7) ev.rx_len = 4'($urandom_range(15, 8));
    end else begin
      ev.kind = ($urandom_range(1) == 0) ? KIND_SPARE_LO : KIND_SPARE_HI;
    end
    return ev;
  endfunction

  function automatic string frame_str(ccf_out_t f);
    return $sformatf("v%0b id %h len %0d data %h last %0b volt %h estop %0b link %0b",
                     f.frame_valid, f.frame_id, f.frame_len, f.frame_data, f.last,
                     f.voltage_decivolts, f.estop_active, f.link_seen);
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= '{index: idx, value: val};
    do @(posedge clk); while (!cfg_if.ready);
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pend_events.size() != 0 || ev_if.valid || expected_frames.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // event driver
  always @(posedge clk) begin
    if (!rst_n) begin
      ev_if.valid <= 1'b0;
    end else begin
      if (ev_if.valid && ev_if.ready) frame_event(ev_if.data);
      if (!ev_if.valid || ev_if.ready) begin
        if (pend_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          ev_if.valid <= 1'b1;
          ev_if.data  <= pend_events.pop_front();
        end else begin
          ev_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && cfg_if.valid && cfg_if.ready) apply_register(cfg_if.data);
  end

  // frame monitor and receiver stalls
  always @(posedge clk) begin : frame_mon
    ccf_out_t want;
    ccf_out_t got;
    if (rst_n) begin
      if (frm_if.valid && frm_if.ready) begin
        got = frm_if.data;
        if (expected_frames.size() == 0) begin
          mism_cnt++;
          if (mism_cnt <= 10) $display("%0t unexpected frame: %s", $realtime, frame_str(got));
        end else begin
          want = expected_frames.pop_front();
          if (got.frame_valid !== want.frame_valid || got.frame_id !== want.frame_id ||
              got.frame_len !== want.frame_len || got.frame_data !== want.frame_data ||
              got.last !== want.last || got.voltage_decivolts !== want.voltage_decivolts ||
              got.estop_active !== want.estop_active || got.link_seen !== want.link_seen) begin
            mism_cnt++;
            if (mism_cnt <= 10) begin
              $display("%0t frame differs", $realtime);
              $display("  expected %s", frame_str(want));
              $display("  actual   %s", frame_str(got));
            end
          end
        end
      end
      if (hold_token != hold_seen) begin
        hold_seen    <= hold_token;
        hold_left    <= LONG_HOLD;
        frm_if.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left    <= hold_left - 1;
        frm_if.ready <= 1'b0;
      end else begin
        frm_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // end the run if no transfer happens for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((ev_if.valid && ev_if.ready) || (frm_if.valid && frm_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("chassis_can_command_framer: mismatch");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : main_seq
    logic [15:0] ph_lin[NUM_PHASES];
    logic [15:0] ph_spin[NUM_PHASES];
    logic [15:0] ph_settle[NUM_PHASES];
    int ph_send[NUM_PHASES];
    int ph_recv[NUM_PHASES];
    ph_lin    = '{16'hFFFF, 16'd0, 16'd1000, 16'd20000, 16'd1500, 16'd7, 16'd25000};
    ph_spin   = '{16'd0, 16'h7FFF, 16'd3259, 16'd500, 16'h8CBB, 16'd12000, 16'd25000};
    ph_settle = '{16'd0, 16'd1, 16'd3, 16'hFFFF, 16'd2, 16'd0, 16'd4};
    ph_send   = '{0, 69, 0, 7, 0, 69, 0};
    ph_recv   = '{0, 0, 69, 7, 0, 0, 69};

    rst_n        = 1'b0;
    ev_if.valid  = 1'b0;
    ev_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    frm_if.ready = 1'b0;
    lin_lim    = LINEAR_LIMIT_RST;
    spin_lim   = SPIN_LIMIT_RST;
    settle_cfg = SETTLE_TICKS_RST;
    en_q       = 1'b0;
    goal_mode  = MODE_ACKERMANN;
    act_mode   = {1'b0, MODE_ACKERMANN};
    hold_lin   = '0;
    hold_ang   = '0;
    settle_cnt = '0;
    batt_v     = '0;
    estop_q    = 1'b0;
    link_q     = 1'b0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset limits and settle window
    pend_events.push_back(mk_event(KIND_TICK, MODE_ACKERMANN, 0, 0, 0, 0, 0));
    pend_events.push_back(mk_event(KIND_DRIVE, MODE_SPIN, 16'sh7FFF, 16'sh7FFF, 0, 0, 0));
    pend_events.push_back(mk_event(KIND_FEEDBACK, MODE_ACKERMANN, 0, 0, ID_FB_SYSTEM,
                                   LEN_FULL, 64'h0000_FFFF_0000_0080));
    pend_events.push_back(mk_event(KIND_FEEDBACK, MODE_ACKERMANN, 0, 0, ID_FB_SYSTEM,
                                   4'd7, 64'h0000_5555_0000_0000));
    pend_events.push_back(mk_event(KIND_FEEDBACK, MODE_ACKERMANN, 0, 0, ID_FB_SYSTEM,
                                   4'd15, 64'hFFFF_1234_FFFF_FF7F));
    pend_events.push_back(mk_event(KIND_FEEDBACK, MODE_PARK, 16'shFFFF, 16'shFFFF,
                                   29'h1FFF_FFFF, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF));
    pend_events.push_back(mk_event(KIND_CLEAR, MODE_ACKERMANN, 0, 0, 0, 0, 0));
    pend_events.push_back(mk_event(KIND_DISABLE, MODE_ACKERMANN, 0, 0, 0, 0, 0));
    pend_events.push_back(mk_event(KIND_ENABLE, MODE_ACKERMANN, 0, 0, 0, 0, 0));
    pend_events.push_back(mk_event(KIND_TICK, MODE_ACKERMANN, 0, 0, 0, 0, 0));
    pend_events.push_back(mk_event(KIND_DRIVE, MODE_ACKERMANN, 16'sh8000, 16'sh7FFF, 0, 0, 0));
    pend_events.push_back(mk_event(KIND_TICK, MODE_ACKERMANN, 0, 0, 0, 0, 0));
    pend_events.push_back(mk_event(KIND_DRIVE, MODE_TILT, 16'sh7FFF, 0, 0, 0, 0));
    pend_events.push_back(mk_event(KIND_TICK, MODE_ACKERMANN, 0, 0, 0, 0, 0));
    pend_events.push_back(mk_event(KIND_DRIVE, MODE_PARK, 16'sd100, 16'sd100, 0, 0, 0));
    pend_events.push_back(mk_event(KIND_TICK, MODE_ACKERMANN, 0, 0, 0, 0, 0));
    pend_events.push_back(mk_event(KIND_DRIVE, MODE_SPIN, 16'sd5, 16'sh8000, 0, 0, 0));
    pend_events.push_back(mk_event(KIND_TICK, MODE_ACKERMANN, 0, 0, 0, 0, 0));
    pend_events.push_back(mk_event(KIND_SPARE_LO, MODE_SPIN, 16'sd1, 16'sd1, 0, 0, 0));
    pend_events.push_back(mk_event(KIND_SPARE_HI, MODE_TILT, 16'sd1, 16'sd1, 0, 0, 0));
    pend_events.push_back(mk_event(KIND_TICK, MODE_ACKERMANN, 0, 0, 0, 0, 0));
    pend_events.push_back(mk_event(KIND_DISABLE, MODE_ACKERMANN, 0, 0, 0, 0, 0));
    pend_events.push_back(mk_event(KIND_TICK, MODE_ACKERMANN, 0, 0, 0, 0, 0));
    pend_events.push_back(mk_event(KIND_ENABLE, MODE_ACKERMANN, 0, 0, 0, 0, 0));
    pend_events.push_back(mk_event(KIND_TICK, MODE_ACKERMANN, 0, 0, 0, 0, 0));
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(REG_LINEAR_LIMIT, ph_lin[p]);
      write_reg(REG_SPIN_LIMIT, ph_spin[p]);
      write_reg(REG_SETTLE_TICKS, ph_settle[p]);
      if (p == 4) write_reg(REG_UNUSED, 16'hFFFF);
      cfg_if.valid   <= 1'b0;
      send_idle_pct  = ph_send[p];
      recv_stall_pct = ph_recv[p];
      // hold the receiver off while the sender keeps offering events
      if (p == 2) hold_token++;
      for (int i = 0; i < PHASE_ITEMS; i++) pend_events.push_back(rand_event());
      wait_drained();
    end

    repeat (20) @(posedge clk);
    if (mism_cnt == 0 && expected_frames.size() == 0) begin
      $display("chassis_can_command_framer: match");
    end else begin
      $display("chassis_can_command_framer: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/ccf_pkg.sv
sv/ccf_stream_if.sv
sv/ccf_core.sv
sv/ccf_out_fifo.sv
sv/chassis_can_command_framer.sv
dv/tb_chassis_can_command_framer.sv
